// File: rtl/bzp_pkg.sv
`default_nettype none

package bzp_pkg;

	localparam int COORD_W    = 21;
	localparam int T_W        = 17;
	localparam int T_FRAC     = 16;
	localparam int CNT_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 63;

	localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

	typedef logic signed [COORD_W-1:0] coord_t;

	// Packed so that x sits in bits 20:0, y in 41:21 and z in 62:42.
	typedef coord_t [2:0] vec3_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_COUNT  = 3'd0,
		REG_CTRL_POINT_0 = 3'd1,
		REG_CTRL_POINT_1 = 3'd2,
		REG_CTRL_POINT_2 = 3'd3,
		REG_CTRL_POINT_3 = 3'd4
	} cfg_reg_t;

endpackage

`default_nettype wire

// File: rtl/bzp_level.sv
`default_nettype none

module bzp_level #(
	parameter int NP    = 4,
	parameter int LEVEL = 1
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            active,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [bzp_pkg::T_W-1:0]         t_in,
	input  wire bzp_pkg::vec3_t [NP-1:0]         pts_in,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [bzp_pkg::T_W-1:0]              t_out,
	output bzp_pkg::vec3_t [NP-1:0]              pts_out
);

	import bzp_pkg::*;

	localparam int NL = NP - LEVEL;
	localparam int PROD_W = COORD_W + T_W + 2;

	logic              v_s1, v_s2;
	logic              act_s1;
	logic [T_W-1:0]    t_s1, t_s2;
	vec3_t [NP-1:0]    a_s1, pts_s2;
	vec3_t [NP-1:0]    q_s1, q_d;
	vec3_t [NP-1:0]    nxt;
	logic              adv1, adv2;

	assign adv2     = !v_s2 || out_ready;
	assign adv1     = !v_s1 || adv2;
	assign in_ready = adv1;

	// First stage: difference and product; only the fractional-shifted slice is kept.
	genvar i, c;
	generate
		for (i = 0; i < NP; i++) begin : g_pt
			for (c = 0; c < 3; c++) begin : g_co
				if (i < NL) begin : g_lerp
					logic signed [COORD_W:0]         diff;
					logic signed [PROD_W-1:0]        prod;
					assign diff = $signed({pts_in[i+1][c][COORD_W-1], pts_in[i+1][c]})
						- $signed({pts_in[i][c][COORD_W-1], pts_in[i][c]});
					assign prod = PROD_W'(diff) * PROD_W'($signed({1'b0, t_in}));
					assign q_d[i][c] = prod[T_FRAC+COORD_W-1:T_FRAC];
					assign nxt[i][c] = act_s1 ? coord_t'(a_s1[i][c] + q_s1[i][c])
						: a_s1[i][c];
				end else begin : g_pass
					assign q_d[i][c] = '0;
					assign nxt[i][c] = a_s1[i][c];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv1) begin
			t_s1   <= t_in;
			a_s1   <= pts_in;
			q_s1   <= q_d;
			act_s1 <= active;
		end
		if (v_s1 && adv2) begin
			t_s2   <= t_s1;
			pts_s2 <= nxt;
		end
	end

	assign out_valid = v_s2;
	assign t_out     = t_s2;
	assign pts_out   = pts_s2;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !adv2 |=> v_s1 && $stable(q_s1) && $stable(a_s1))
		else $error("first stage changed while blocked");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !out_ready |=> v_s2 && $stable(pts_s2))
		else $error("second stage changed while blocked");

	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv2 |=> v_s2 && t_s2 == $past(t_s1))
		else $error("item lost between stages");

endmodule

`default_nettype wire

// File: rtl/bezier_point_evaluator.sv
`default_nettype none
// Pipeline: each interpolation level is a multiply stage and an add stage, with per-stage
// valid bits. Throughput: one request per cycle while pos_ready does not stall the output;
// a stalled result only backs up full stages.
// Reset: arst_n clears all valid bits, sets point_count to 4 and the control points to 0.

module bezier_point_evaluator #(
	parameter int MAX_POINTS = 4
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [bzp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bzp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic                                t_valid,
	output logic                                     t_ready,
	input  wire logic [bzp_pkg::T_W-1:0]             t_param,
	output logic                                     pos_valid,
	input  wire logic                                pos_ready,
	output logic signed [bzp_pkg::COORD_W-1:0]       pos_x,
	output logic signed [bzp_pkg::COORD_W-1:0]       pos_y,
	output logic signed [bzp_pkg::COORD_W-1:0]       pos_z
);

	import bzp_pkg::*;

	// One de Casteljau level per pipeline slice; level k reduces the live points by one.
	localparam int NLVL = MAX_POINTS - 1;

	logic [CNT_W-1:0]          count_q;
	vec3_t [MAX_POINTS-1:0]    ctrl_q;
	logic [CNT_W-1:0]          n_eff;
	logic [T_W-1:0]            t_sat;

	vec3_t [MAX_POINTS-1:0]    lvl_pts [0:NLVL];
	logic [T_W-1:0]            lvl_t   [0:NLVL];
	logic [NLVL:0]             lvl_valid;
	logic [NLVL:0]             lvl_ready;

	// Configuration registers. Writes to indexes beyond the stored points are dropped,
	// since those points can never take part in a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CNT_W'(4);
		end else if (cfg_we && cfg_index == REG_POINT_COUNT) begin
			count_q <= cfg_data[CNT_W-1:0];
		end
	end

	genvar j;
	generate
		for (j = 0; j < MAX_POINTS; j++) begin : g_ctrl
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					ctrl_q[j] <= '0;
				end else if (cfg_we &&
					cfg_index == CFG_IDX_W'(REG_CTRL_POINT_0) + CFG_IDX_W'(j)) begin
					ctrl_q[j] <= cfg_data;
				end
			end
		end
	endgenerate

	// Point counts above the stored depth behave as the full depth.
	assign n_eff = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;

	// Parameters above one behave as exactly one, which lands on the last live point.
	assign t_sat = (t_param > T_ONE) ? T_ONE : t_param;

	assign lvl_pts[0]   = ctrl_q;
	assign lvl_t[0]     = t_sat;
	assign lvl_valid[0] = t_valid;
	assign t_ready      = lvl_ready[0];

	// The user must change configuration only with the pipeline empty (the block itself does
	// not enforce it), so each level can read the live point count directly. A level at or
	// beyond the count passes its points through, which leaves the answer in entry 0 after the last active level.
	genvar k;
	generate
		for (k = 1; k <= NLVL; k++) begin : g_lvl
			bzp_level #(
				.NP    (MAX_POINTS),
				.LEVEL (k)
			) u_level (
				.clk       (clk),
				.arst_n    (arst_n),
				.active    (n_eff > CNT_W'(k)),
				.in_valid  (lvl_valid[k-1]),
				.in_ready  (lvl_ready[k-1]),
				.t_in      (lvl_t[k-1]),
				.pts_in    (lvl_pts[k-1]),
				.out_valid (lvl_valid[k]),
				.out_ready (lvl_ready[k]),
				.t_out     (lvl_t[k]),
				.pts_out   (lvl_pts[k])
			);
		end
	endgenerate

	assign pos_valid       = lvl_valid[NLVL];
	assign lvl_ready[NLVL] = pos_ready;

	// With no points in use the curve collapses to the origin.
	assign pos_x = (n_eff == '0) ? '0 : lvl_pts[NLVL][0][0];
	assign pos_y = (n_eff == '0) ? '0 : lvl_pts[NLVL][0][1];
	assign pos_z = (n_eff == '0) ? '0 : lvl_pts[NLVL][0][2];

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_eff <= CNT_W'(MAX_POINTS))
		else $error("effective point count exceeds storage");

	a_t_range: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_valid[0] |-> lvl_t[0] <= T_ONE)
		else $error("parameter not saturated");

	a_empty_pipe_ready: assert property (@(posedge clk) disable iff (!arst_n)
		lvl_valid[NLVL:1] == '0 |-> t_ready)
		else $error("empty pipeline refuses a request");

endmodule

`default_nettype wire
